>>> hdl/gmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmr_pkg: shared types and constants for the genotype mismatch rate block
// Transaction structs, sequencer states and the count limit.
// ----------------------------------------------------------------------------
package gmr_pkg;

   localparam int unsigned CountWidth = 17;
   localparam int unsigned MaxMarkers = 65536;
   localparam int unsigned CountCapInt = (MaxMarkers < 131071) ? MaxMarkers : 131071;
   localparam logic [CountWidth-1:0] COUNT_CAP = CountWidth'(CountCapInt);

   // quotient bits produced by the shared divider, one per cycle
   localparam int unsigned DivSteps = 17;
   localparam int unsigned StepWidth = $clog2(DivSteps + 1);
   localparam int unsigned FracBits = 16;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_TWO  = 8'h32;
   localparam logic [7:0] CHAR_NUL  = 8'h00;

   typedef struct packed {
      logic [7:0] genotype_a;
      logic [7:0] genotype_b;
      logic       last_pair;
   } gmr_req_type;

   typedef struct packed {
      logic [CountWidth-1:0] usable_count;
      logic [CountWidth-1:0] mismatch_count;
      logic [CountWidth-1:0] mismatch_rate;
      logic                  no_usable;
   } gmr_rsp_type;

   typedef enum logic [0:0] {
      GMR_ACCUM,
      GMR_DIVIDE
   } gmr_state_type;

   function automatic logic is_genotype(input logic [7:0] c);
      return (c == CHAR_ZERO) || (c == CHAR_ONE) || (c == CHAR_TWO);
   endfunction

endpackage

>>> hdl/genotype_mismatch_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genotype_mismatch_rate: per-record genotype mismatch counter and rate
// Tallies usable and mismatching marker pairs, then divides once per record.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one marker pair (two character bytes plus last_pair) per
//   transaction. While a record streams in, one transaction is taken every
//   cycle. A zero byte in either position ends comparison for the record;
//   later pairs are ignored until last_pair.
//   On the transaction with last_pair set, the tallies move into a shared
//   restoring divider that yields one quotient bit per cycle. req_stall is
//   high while the divider steps and while the result loads into the
//   output register that drives rsp_*.
//   rsp_* is an output register: a new record may stream in while a result
//   waits. If the receiver still stalls when the next division finishes,
//   the block holds req_stall until the output register frees.
//   mismatch_rate is floor(mismatches * 2^16 / usable); with no usable pair
//   it is 0 and no_usable is set.
//   Reset (synchronous, active high) clears the tallies, the sequencer and
//   rsp_valid.
// ----------------------------------------------------------------------------
module genotype_mismatch_rate
   import gmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  gmr_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output gmr_rsp_type rsp_payload
);

   gmr_state_type state_ff, state_in;

   // running tallies for the record in progress
   logic [CountWidth-1:0] usable_ff, usable_in;
   logic [CountWidth-1:0] mismatch_ff, mismatch_in;
   logic                  ended_ff, ended_in;

   // divider operands and working registers
   logic [CountWidth-1:0] den_ff, den_in;       // usable count, also reported
   logic [CountWidth-1:0] mis_ff, mis_in;       // mismatch count, reported
   logic [CountWidth-1:0] rem_ff, rem_in;       // partial remainder, < den if den nonzero
   logic [CountWidth-1:0] quo_ff, quo_in;
   logic [CountWidth-1:0] bits_ff, bits_in;     // dividend bits still to shift in
   logic [StepWidth-1:0]  step_ff, step_in;

   logic        rsp_valid_ff, rsp_valid_in;
   gmr_rsp_type rsp_ff, rsp_in;

   logic req_take;
   logic out_free;
   logic [CountWidth-1:0] tally_u, tally_m;
   logic [CountWidth:0]   trial;
   logic [CountWidth:0]   diff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != GMR_ACCUM);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // tally update for the incoming pair
   always_comb begin
      tally_u  = usable_ff;
      tally_m  = mismatch_ff;
      ended_in = ended_ff;
      if (!ended_ff) begin
         if (req_payload.genotype_a == CHAR_NUL || req_payload.genotype_b == CHAR_NUL) begin
            ended_in = 1'b1;
         end else if (is_genotype(req_payload.genotype_a)
                      && is_genotype(req_payload.genotype_b)
                      && usable_ff < COUNT_CAP) begin
            tally_u = usable_ff + 1'b1;
            if (req_payload.genotype_a != req_payload.genotype_b) begin
               tally_m = mismatch_ff + 1'b1;
            end
         end
      end
   end

   // one restoring step: shift in next dividend bit, try to subtract
   assign trial = {rem_ff, bits_ff[CountWidth-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      state_in     = state_ff;
      usable_in    = usable_ff;
      mismatch_in  = mismatch_ff;
      den_in       = den_ff;
      mis_in       = mis_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bits_in      = bits_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         GMR_ACCUM: begin
            if (req_take) begin
               if (req_payload.last_pair) begin
                  den_in      = tally_u;
                  mis_in      = tally_m;
                  // top dividend bits: mismatch >> 1 is below usable whenever usable is nonzero
                  rem_in      = {1'b0, tally_m[CountWidth-1:1]};
                  bits_in     = {tally_m[0], {FracBits{1'b0}}};
                  quo_in      = '0;
                  step_in     = '0;
                  usable_in   = '0;
                  mismatch_in = '0;
                  state_in    = GMR_DIVIDE;
               end else begin
                  usable_in   = tally_u;
                  mismatch_in = tally_m;
               end
            end
         end
         GMR_DIVIDE: begin
            if (step_ff != StepWidth'(DivSteps)) begin
               if (!diff[CountWidth]) begin
                  rem_in = diff[CountWidth-1:0];
               end else begin
                  rem_in = trial[CountWidth-1:0];
               end
               quo_in  = {quo_ff[CountWidth-2:0], !diff[CountWidth]};
               bits_in = {bits_ff[CountWidth-2:0], 1'b0};
               step_in = step_ff + 1'b1;
            end else if (out_free) begin
               rsp_in.usable_count   = den_ff;
               rsp_in.mismatch_count = mis_ff;
               rsp_in.no_usable      = (den_ff == '0);
               rsp_in.mismatch_rate  = (den_ff == '0) ? '0 : quo_ff;
               rsp_valid_in          = 1'b1;
               state_in              = GMR_ACCUM;
            end
         end
         default: state_in = GMR_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= GMR_ACCUM;
         usable_ff    <= '0;
         mismatch_ff  <= '0;
         ended_ff     <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         usable_ff    <= usable_in;
         mismatch_ff  <= mismatch_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            ended_ff <= req_payload.last_pair ? 1'b0 : ended_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      mis_ff  <= mis_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      bits_ff <= bits_in;
      rsp_ff  <= rsp_in;
   end

endmodule
